### src/pps_pkg.sv
`default_nettype none

package pps_pkg;

    localparam int SLOTS_DEF     = 8;
    localparam int TIME_BITS_DEF = 16;

    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 12;
    localparam int PRIO_W  = 8;
    localparam int OUT_T_W = 16;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SLOT_W-1:0]  slot;
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_length;
        logic [PRIO_W-1:0]  job_priority;
    } item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  ran_slot;
        logic               idle;
        logic               job_done;
        logic [OUT_T_W-1:0] start_time;
        logic [OUT_T_W-1:0] finish_time;
        logic [OUT_T_W-1:0] turnaround;
        logic [OUT_T_W-1:0] waiting;
        logic [OUT_T_W-1:0] response;
        logic               all_done;
    } result_t;

endpackage

`default_nettype wire

### src/pps_table.sv
`default_nettype none

module pps_table #(
    parameter int DEPTH = pps_pkg::SLOTS_DEF,
    parameter int WIDTH = 64,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/preemptive_priority_scheduler.sv
`default_nettype none

// Preemptive priority scheduler over SLOTS job slots. Each item is a load, a
// tick or a clear (any other op code does nothing) and returns exactly one
// result transfer. A load or a clear passes through the finish state, which
// registers its result, and the next item can be accepted once the machine is
// back in idle. A tick reads the slot table through its single read port, one
// slot per cycle in the scan state, then passes the last state; when a job is
// served it adds the update state, and when the served job completes also the
// turn and wait states (for the turnaround, response and waiting subtractions),
// before the finish state registers the result. Input is stalled while an item
// is in work; a finished result waits in an output register and does not block
// the next item until that item's own result is ready.

module preemptive_priority_scheduler #(
    parameter int SLOTS     = pps_pkg::SLOTS_DEF,
    parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire pps_pkg::item_t  item,
    input  wire logic            item_valid,
    output logic                 item_stall,
    output pps_pkg::result_t     result,
    output logic                 result_valid,
    input  wire logic            result_stall
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CMP_W   = (TIME_BITS > pps_pkg::ARR_W) ? TIME_BITS : pps_pkg::ARR_W;
    localparam int ENTRY_W = pps_pkg::ARR_W + 2 * pps_pkg::BURST_W + pps_pkg::PRIO_W
                             + TIME_BITS;

    typedef struct packed {
        logic [pps_pkg::ARR_W-1:0]   arrival;
        logic [pps_pkg::BURST_W-1:0] burst;
        logic [pps_pkg::PRIO_W-1:0]  prio;
        logic [pps_pkg::BURST_W-1:0] remaining;
        logic [TIME_BITS-1:0]        start;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_UPDATE,
        S_TURN,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t               state_reg,       state_next;
    logic [SLOTS-1:0]     pending_reg,     pending_next;
    logic [SLOTS-1:0]     started_reg,     started_next;
    logic [TIME_BITS-1:0] time_reg,        time_next;
    logic [IDX_W-1:0]     scan_idx_reg,    scan_idx_next;
    logic [IDX_W-1:0]     eval_idx_reg,    eval_idx_next;
    logic                 eval_en_reg,     eval_en_next;
    logic                 found_reg,       found_next;
    logic [IDX_W-1:0]     pick_reg,        pick_next;
    entry_t               best_reg,        best_next;
    logic                 done_reg,        done_next;
    logic                 idle_reg,        idle_next;
    logic [TIME_BITS-1:0] st_reg,          st_next;
    logic [TIME_BITS-1:0] fin_reg,         fin_next;
    logic [CMP_W-1:0]     tat_reg,         tat_next;
    logic [CMP_W-1:0]     resp_reg,        resp_next;
    logic [CMP_W-1:0]     wait_reg,        wait_next;
    pps_pkg::result_t     result_reg,      result_next;
    logic                 result_valid_reg, result_valid_next;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;
    logic [ENTRY_W-1:0]   rd_raw;
    entry_t               rd_entry;

    logic                 accept;
    logic                 eligible;
    logic                 take;
    logic                 slot_ok;
    logic [IDX_W-1:0]     load_idx;
    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] upd_start;
    logic [pps_pkg::BURST_W-1:0] upd_rem;
    logic [CMP_W-1:0]     arr_ext;
    logic [CMP_W-1:0]     fin_ext;
    logic [CMP_W-1:0]     st_ext;
    logic [CMP_W-1:0]     burst_ext;

    pps_table #(
        .DEPTH (SLOTS),
        .WIDTH (ENTRY_W),
        .AW    (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_raw)
    );

    assign rd_entry     = rd_raw;
    assign accept       = item_valid && (state_reg == S_IDLE);
    assign item_stall   = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    assign slot_ok  = (32'(item.slot) < 32'(SLOTS));
    assign load_idx = IDX_W'(item.slot);
    assign time_inc = (time_reg == '1) ? time_reg : time_reg + 1'b1;
    assign upd_start = started_reg[pick_reg] ? best_reg.start : time_reg;
    assign upd_rem   = best_reg.remaining - 1'b1;

    assign eligible = eval_en_reg && pending_reg[eval_idx_reg]
                      && (CMP_W'(rd_entry.arrival) <= CMP_W'(time_reg));
    assign take     = eligible && (!found_reg || (rd_entry.prio > best_reg.prio));

    assign arr_ext   = CMP_W'(best_reg.arrival);
    assign fin_ext   = CMP_W'(fin_reg);
    assign st_ext    = CMP_W'(st_reg);
    assign burst_ext = CMP_W'(best_reg.burst);

    always_comb
    begin
        state_next        = state_reg;
        pending_next      = pending_reg;
        started_next      = started_reg;
        time_next         = time_reg;
        scan_idx_next     = scan_idx_reg;
        eval_idx_next     = eval_idx_reg;
        eval_en_next      = eval_en_reg;
        found_next        = found_reg;
        pick_next         = pick_reg;
        best_next         = best_reg;
        done_next         = done_reg;
        idle_next         = idle_reg;
        st_next           = st_reg;
        fin_next          = fin_reg;
        tat_next          = tat_reg;
        resp_next         = resp_reg;
        wait_next         = wait_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        wr_en             = 1'b0;
        wr_addr           = pick_reg;
        wr_data           = best_reg;
        wr_data.remaining = upd_rem;
        wr_data.start     = upd_start;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        // keep the best candidate seen so far
        if (take)
        begin
            found_next = 1'b1;
            pick_next  = eval_idx_reg;
            best_next  = rd_entry;
        end

        case (state_reg)
            S_IDLE:
            begin
                eval_en_next = 1'b0;
                if (accept)
                begin
                    found_next = 1'b0;
                    done_next  = 1'b0;
                    idle_next  = 1'b0;
                    case (item.op)
                        pps_pkg::OP_LOAD:
                        begin
                            if (slot_ok)
                            begin
                                wr_en             = 1'b1;
                                wr_addr           = load_idx;
                                wr_data.arrival   = item.arrival_time;
                                wr_data.burst     = item.burst_length;
                                wr_data.prio      = item.job_priority;
                                wr_data.remaining = item.burst_length;
                                wr_data.start     = '0;
                                pending_next[load_idx] = (item.burst_length != '0);
                                started_next[load_idx] = 1'b0;
                            end
                            state_next = S_FINISH;
                        end
                        pps_pkg::OP_TICK:
                        begin
                            scan_idx_next = '0;
                            state_next    = S_SCAN;
                        end
                        pps_pkg::OP_CLEAR:
                        begin
                            pending_next = '0;
                            started_next = '0;
                            time_next    = '0;
                            state_next   = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                eval_en_next  = 1'b1;
                eval_idx_next = scan_idx_reg;
                if (scan_idx_reg == IDX_W'(SLOTS - 1))
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                eval_en_next = 1'b0;
                if (found_reg || take)
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    idle_next  = 1'b1;
                    time_next  = time_inc;
                    state_next = S_FINISH;
                end
            end
            S_UPDATE:
            begin
                wr_en                  = 1'b1;
                started_next[pick_reg] = 1'b1;
                time_next              = time_inc;
                st_next                = upd_start;
                fin_next               = time_inc;
                if (upd_rem == '0)
                begin
                    pending_next[pick_reg] = 1'b0;
                    done_next              = 1'b1;
                    state_next             = S_TURN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_TURN:
            begin
                tat_next   = (fin_ext >= arr_ext) ? fin_ext - arr_ext : '0;
                resp_next  = (st_ext >= arr_ext) ? st_ext - arr_ext : '0;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                wait_next  = (tat_reg >= burst_ext) ? tat_reg - burst_ext : '0;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.ran_slot    = found_reg ? pps_pkg::SLOT_W'(pick_reg) : '0;
                    result_next.idle        = idle_reg;
                    result_next.job_done    = done_reg;
                    result_next.start_time  = done_reg ? pps_pkg::OUT_T_W'(st_reg) : '0;
                    result_next.finish_time = done_reg ? pps_pkg::OUT_T_W'(fin_reg) : '0;
                    result_next.turnaround  = done_reg ? pps_pkg::OUT_T_W'(tat_reg) : '0;
                    result_next.waiting     = done_reg ? pps_pkg::OUT_T_W'(wait_reg) : '0;
                    result_next.response    = done_reg ? pps_pkg::OUT_T_W'(resp_reg) : '0;
                    result_next.all_done    = ~|pending_reg;
                    result_valid_next       = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pending_reg      <= '0;
            started_reg      <= '0;
            time_reg         <= '0;
            scan_idx_reg     <= '0;
            eval_idx_reg     <= '0;
            eval_en_reg      <= 1'b0;
            found_reg        <= 1'b0;
            pick_reg         <= '0;
            best_reg         <= '0;
            done_reg         <= 1'b0;
            idle_reg         <= 1'b0;
            st_reg           <= '0;
            fin_reg          <= '0;
            tat_reg          <= '0;
            resp_reg         <= '0;
            wait_reg         <= '0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pending_reg      <= pending_next;
            started_reg      <= started_next;
            time_reg         <= time_next;
            scan_idx_reg     <= scan_idx_next;
            eval_idx_reg     <= eval_idx_next;
            eval_en_reg      <= eval_en_next;
            found_reg        <= found_next;
            pick_reg         <= pick_next;
            best_reg         <= best_next;
            done_reg         <= done_next;
            idle_reg         <= idle_next;
            st_reg           <= st_next;
            fin_reg          <= fin_next;
            tat_reg          <= tat_next;
            resp_reg         <= resp_next;
            wait_reg         <= wait_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

`default_nettype wire
